// ===== rtl/tfa_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// temporal frame averager. No dependencies.
`default_nettype none
package tfa_pkg;

  localparam int unsigned MAX_PIXELS_DEF    = 65536;
  localparam int unsigned SAMPLE_BITS_DEF   = 16;
  localparam int unsigned FRACTION_BITS_DEF = 8;

  localparam int unsigned CFG_W     = 17;
  localparam int unsigned FRAMES_W  = 9;
  localparam int unsigned SEEN_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_TO_AVERAGE = 1'b1;

  localparam logic [CFG_W-1:0]    FRAME_PIXELS_RESET = 17'd65536;
  localparam logic [FRAMES_W-1:0] FRAMES_RESET       = 9'd4;
  localparam logic [FRAMES_W-1:0] FRAMES_MAX         = 9'd256;

  typedef struct packed {
    logic clear;
    logic take;
    logic accum;
    logic divide;
    logic load;
  } tfa_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic emit;
    logic div_done;
  } tfa_status_t;

endpackage
`default_nettype wire

// ===== rtl/tfa_ctrl.sv =====
// Sequencer for the temporal frame averager: clearing pass, request
// intake, accumulate, divide and send. Depends on tfa_pkg.
`default_nettype none
module tfa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output tfa_pkg::tfa_cmd_t   cmd,
  input  tfa_pkg::tfa_status_t status
);
  import tfa_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_ACCUM  = 3'd3;
  localparam logic [2:0] S_DIVIDE = 3'd4;
  localparam logic [2:0] S_SEND   = 3'd5;

  logic [2:0] state, state_next;
  logic       slot_free;

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_ACCUM;
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = status.emit ? S_DIVIDE : S_IDLE;
      end
      S_DIVIDE: begin
        cmd.divide = 1'b1;
        if (status.div_done) state_next = S_SEND;
      end
      S_SEND: begin
        if (slot_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)             out_valid <= 1'b0;
    else if (cmd.load)   out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  assign in_stall = (state != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/tfa_datapath.sv =====
// Datapath of the temporal frame averager: configuration registers,
// accumulator memory, position counters and serial divider. Depends on tfa_pkg.
`default_nettype none
module tfa_datapath #(
  parameter int unsigned MAX_PIXELS    = tfa_pkg::MAX_PIXELS_DEF,
  parameter int unsigned SAMPLE_BITS   = tfa_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRACTION_BITS = tfa_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [tfa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [tfa_pkg::CFG_W-1:0]             cfg_data,
  input  wire logic signed [SAMPLE_BITS-1:0]         sample,
  output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] average,
  output logic                                       frame_end,
  input  tfa_pkg::tfa_cmd_t                          cmd,
  output tfa_pkg::tfa_status_t                       status
);
  import tfa_pkg::*;

  localparam int unsigned POS_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CLR_W = POS_W + 1;
  localparam int unsigned CNT_W = (CFG_W > CLR_W) ? CFG_W : CLR_W;
  localparam int unsigned SUM_W = SAMPLE_BITS + FRAMES_W;
  localparam int unsigned AVG_W = SAMPLE_BITS + FRACTION_BITS;
  localparam int unsigned QW    = SUM_W + FRACTION_BITS;
  localparam int unsigned DC_W  = $clog2(QW + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);
  localparam logic [QW-1:0] POS_LIMIT = QW'((64'd1 << (AVG_W - 1)) - 64'd1);
  localparam logic [QW-1:0] NEG_LIMIT = QW'(64'd1 << (AVG_W - 1));

  logic [CFG_W-1:0]    frame_pixels;
  logic [FRAMES_W-1:0] frames_to_average;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pixels      <= FRAME_PIXELS_RESET;
      frames_to_average <= FRAMES_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_FRAME_PIXELS)      frame_pixels      <= cfg_data;
      if (cfg_index == REG_FRAMES_TO_AVERAGE) frames_to_average <= cfg_data[FRAMES_W-1:0];
    end
  end

  logic [CNT_W-1:0]    eff_pixels;
  logic [FRAMES_W-1:0] eff_frames;
  always_comb begin
    eff_pixels = CNT_W'(frame_pixels);
    if (frame_pixels == '0) eff_pixels = CNT_W'(1);
    else if (CNT_W'(frame_pixels) > MAX_CNT) eff_pixels = MAX_CNT;
    eff_frames = frames_to_average;
    if (frames_to_average == '0) eff_frames = FRAMES_W'(1);
    else if (frames_to_average > FRAMES_MAX) eff_frames = FRAMES_MAX;
  end

  logic [CLR_W-1:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst)            clr_cnt <= '0;
    else if (cmd.clear && !status.clear_done) clr_cnt <= clr_cnt + CLR_W'(1);
  end
  assign status.clear_done = (CNT_W'(clr_cnt) >= MAX_CNT);

  logic [POS_W-1:0]  position;
  logic [SEEN_W-1:0] frames_seen;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic last_q, emit_q;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sample_q <= sample;
      last_q   <= (CNT_W'(position) >= eff_pixels - CNT_W'(1));
      emit_q   <= (FRAMES_W'(frames_seen) >= eff_frames - FRAMES_W'(1));
    end
  end
  assign status.emit = emit_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      frames_seen <= '0;
    end else if (cmd.accum) begin
      if (last_q) begin
        position    <= '0;
        frames_seen <= emit_q ? '0 : frames_seen + SEEN_W'(1);
      end else begin
        position <= position + POS_W'(1);
      end
    end
  end

  logic signed [SUM_W-1:0] mem [MAX_PIXELS];
  logic signed [SUM_W-1:0] rd_data;
  logic signed [SUM_W-1:0] sum;
  logic                    wr_en;
  logic [POS_W-1:0]        wr_addr;
  logic signed [SUM_W-1:0] wr_data;

  assign sum     = rd_data + SUM_W'(sample_q);
  assign wr_en   = (cmd.clear && !status.clear_done) || cmd.accum;
  assign wr_addr = cmd.clear ? clr_cnt[POS_W-1:0] : position;
  assign wr_data = (cmd.clear || emit_q) ? '0 : sum;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.take) rd_data <= mem[position];
  end

  logic [QW-1:0]       quo;
  logic [FRAMES_W-1:0] rem;
  logic [FRAMES_W:0]   trial;
  logic [DC_W-1:0]     div_cnt;
  logic                neg;
  logic [SUM_W-1:0]    mag;
  logic signed [AVG_W-1:0] avg_sat;

  assign mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign trial = {rem, quo[QW-1]};

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      quo     <= QW'(mag) << FRACTION_BITS;
      rem     <= '0;
      neg     <= sum[SUM_W-1];
      div_cnt <= DC_W'(QW);
    end else if (cmd.divide && !status.div_done) begin
      div_cnt <= div_cnt - DC_W'(1);
      if (trial >= (FRAMES_W+1)'(eff_frames)) begin
        rem <= FRAMES_W'(trial - (FRAMES_W+1)'(eff_frames));
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= trial[FRAMES_W-1:0];
        quo <= {quo[QW-2:0], 1'b0};
      end
    end
  end
  assign status.div_done = (div_cnt == '0);

  always_comb begin
    if (!neg) avg_sat = (quo > POS_LIMIT) ? AVG_W'(POS_LIMIT) : AVG_W'(quo);
    else      avg_sat = (quo > NEG_LIMIT) ? AVG_W'(NEG_LIMIT) : AVG_W'(-quo);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      average   <= avg_sat;
      frame_end <= last_q;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/temporal_frame_averager.sv =====
// Temporal frame averager: sums each pixel over frames_to_average frames and
// emits the signed Q16.8 mean on the last frame, clearing the sum as it goes.
// One request at a time through the arithmetic: a request that yields a result
// also passes through the one-bit-a-cycle restoring divider and the load into
// the output register, which waits while the previous result is still held
// there. A result held in the output register does not block the next request.
// After reset a clearing pass zeroes the accumulator memory while input stays
// stalled; configuration writes are taken throughout.
// Depends on tfa_pkg, tfa_ctrl and tfa_datapath.
`default_nettype none
module temporal_frame_averager #(
  parameter int unsigned MAX_PIXELS    = tfa_pkg::MAX_PIXELS_DEF,
  parameter int unsigned SAMPLE_BITS   = tfa_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRACTION_BITS = tfa_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_write,
  input  wire logic [tfa_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [tfa_pkg::CFG_W-1:0]              cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]          sample,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] average,
  output logic                                        frame_end
);
  import tfa_pkg::*;

  tfa_cmd_t    cmd;
  tfa_status_t status;

  tfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  tfa_datapath #(
    .MAX_PIXELS    (MAX_PIXELS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .average   (average),
    .frame_end (frame_end),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire

// ===== sim/tfa_checker.sv =====
// Checker for the temporal frame averager: tracks register writes, predicts the
// mean for each accepted request that closes a run of frames and compares it
// with what leaves the block. Depends on tfa_pkg.
module tfa_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [tfa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tfa_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [15:0]                   sample,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [23:0]                   average,
  input  logic                                 frame_end,
  output int                                   errors,
  output int                                   means_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIXELS = 65536;
  localparam longint MEAN_HI = 64'sd8388607;
  localparam longint MEAN_LO = -64'sd8388608;

  typedef struct packed {
    logic signed [23:0] mean;
    logic               last;
  } pixel_mean_t;

  logic [tfa_pkg::CFG_W-1:0]    pixels_per_frame;
  logic [tfa_pkg::FRAMES_W-1:0] frames_per_mean;
  longint                       frame_sums [PIXELS];
  int                           raster_pos;
  int                           frames_done;
  pixel_mean_t                  mean_q [$];

  assign means_due = mean_q.size();

  task automatic absorb_sample(input logic signed [15:0] s);
    int          npix;
    int          nfr;
    int          pos;
    bit          last;
    bit          emit;
    longint      acc;
    longint      q;
    pixel_mean_t m;
    npix = (pixels_per_frame == 0) ? 1 : (pixels_per_frame > PIXELS ? PIXELS : pixels_per_frame);
    nfr = (frames_per_mean == 0) ? 1 :
          (frames_per_mean > tfa_pkg::FRAMES_MAX ? tfa_pkg::FRAMES_MAX : frames_per_mean);
    pos = (raster_pos >= PIXELS) ? PIXELS - 1 : raster_pos;
    last = pos >= npix - 1;
    emit = frames_done >= nfr - 1;
    acc = frame_sums[pos] + longint'(s);
    if (emit) begin
      q = (acc * 256) / nfr;
      if (q > MEAN_HI) q = MEAN_HI;
      if (q < MEAN_LO) q = MEAN_LO;
      m.mean = q[23:0];
      m.last = last;
      mean_q.push_back(m);
      frame_sums[pos] = 0;
    end else begin
      frame_sums[pos] = acc;
    end
    if (last) begin
      raster_pos = 0;
      frames_done = emit ? 0 : frames_done + 1;
    end else begin
      raster_pos = pos + 1;
    end
  endtask

  always @(posedge clk) begin
    pixel_mean_t m;
    if (rst) begin
      for (int i = 0; i < PIXELS; i++) frame_sums[i] = 0;
      raster_pos = 0;
      frames_done = 0;
      pixels_per_frame = tfa_pkg::FRAME_PIXELS_RESET;
      frames_per_mean = tfa_pkg::FRAMES_RESET;
      mean_q.delete();
      errors = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == tfa_pkg::REG_FRAME_PIXELS) pixels_per_frame = cfg_data;
        else if (cfg_index == tfa_pkg::REG_FRAMES_TO_AVERAGE)
          frames_per_mean = cfg_data[tfa_pkg::FRAMES_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (mean_q.size() == 0) begin
          $display("%0t: unexpected result average=%0d frame_end=%0b",
                   $time, average, frame_end);
          errors++;
        end else begin
          m = mean_q.pop_front();
          if (average !== m.mean) begin
            $display("%0t: average expected %0d actual %0d", $time, m.mean, average);
            errors++;
          end
          if (frame_end !== m.last) begin
            $display("%0t: frame_end expected %0b actual %0b", $time, m.last, frame_end);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) absorb_sample(sample);
    end
  end
endmodule

// ===== sim/tb.sv =====
// Testbench top for the temporal frame averager: resets, writes registers
// between phases, feeds directed and random pixels and gives the verdict.
// Depends on tfa_pkg, temporal_frame_averager and tfa_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [tfa_pkg::CFG_IDX_W-1:0] cfg_index = tfa_pkg::REG_FRAME_PIXELS;
  logic [tfa_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [15:0]            sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [23:0]            average;
  logic                          frame_end;
  int                            errors;
  int                            means_due;
  bit                            quiet = 1'b0;
  int                            fed;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  temporal_frame_averager uut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .in_valid, .in_stall, .sample,
    .out_valid, .out_stall, .average, .frame_end
  );

  tfa_checker chk (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .in_valid, .in_stall, .sample,
    .out_valid, .out_stall, .average, .frame_end, .errors, .means_due
  );

  always @(negedge clk) out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 30);

  task automatic write_reg(input logic [tfa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tfa_pkg::CFG_W-1:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic send_pixel(input logic signed [15:0] s);
    while (!quiet && $urandom_range(99) < 30) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample = s;
    while (in_stall) @(negedge clk);
    @(negedge clk);
    fed++;
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (means_due != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic set_mode(input logic [tfa_pkg::CFG_W-1:0] npix,
                          input logic [tfa_pkg::CFG_W-1:0] nfr);
    drain();
    write_reg(tfa_pkg::REG_FRAME_PIXELS, npix);
    write_reg(tfa_pkg::REG_FRAMES_TO_AVERAGE, nfr);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [tfa_pkg::CFG_W-1:0] pick_pixels();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 17'($urandom_range(6, 1));
    if (r < 80) return 17'd0;
    if (r < 90) return 17'($urandom_range(40, 7));
    case ($urandom_range(2))
      0: return 17'd65536;
      1: return 17'h1ffff;
      default: return 17'($urandom);
    endcase
  endfunction

  function automatic logic [tfa_pkg::CFG_W-1:0] pick_frames();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 17'($urandom_range(4, 1));
    if (r < 70) return 17'd0;
    if (r < 85) return 17'($urandom_range(16, 5));
    case ($urandom_range(2))
      0: return 17'd256;
      1: return 17'h1ffff;
      default: return 17'($urandom);
    endcase
  endfunction

  initial begin
    int phase;
    int n;
    fed = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single-pixel frames, mean of one: extremes pass straight through
    write_reg(tfa_pkg::REG_FRAME_PIXELS, 17'd1);
    write_reg(tfa_pkg::REG_FRAMES_TO_AVERAGE, 17'd1);
    send_pixel(16'sh8000);
    send_pixel(16'sh7fff);
    send_pixel(16'sh0000);
    send_pixel(16'shffff);
    // full-size frame, left mid-frame for a shortened one
    set_mode(17'd65536, 17'd1);
    repeat (3) send_pixel(pick_sample());
    set_mode(17'd3, 17'd2);
    repeat (4) send_pixel(pick_sample());
    // zero length and zero count taken as one
    set_mode(17'd0, 17'd0);
    send_pixel(16'sh1234);
    send_pixel(-16'sd7);
    // oversized count, then a drop to one: saturate both ways
    set_mode(17'd1, 17'h1ff);
    repeat (4) send_pixel(16'sh7fff);
    set_mode(17'd1, 17'd1);
    send_pixel(16'sh7fff);
    set_mode(17'd1, 17'd256);
    repeat (4) send_pixel(16'sh8000);
    set_mode(17'd1, 17'd1);
    send_pixel(16'sh8000);

    phase = 0;
    fed = 0;
    while (fed < 1200) begin
      set_mode(pick_pixels(), pick_frames());
      quiet = (phase >= 6 && phase < 9);
      n = $urandom_range(60, 20);
      repeat (n) send_pixel(pick_sample());
      phase++;
    end
    quiet = 1'b0;
    drain();
    if (errors == 0 && means_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
